[design/wlr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package wlr_pkg;

  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CH_NUL     = 8'h00;

  // depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [7:0] byte_val;
    logic       is_letter;
  } wlr_item_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_POP,
    BK_EMIT,
    BK_SEP
  } back_state_t;

  function automatic logic is_letter(input logic [7:0] b);
    is_letter = ((b >= CH_UPPER_A) && (b <= CH_UPPER_Z)) ||
                ((b >= CH_LOWER_A) && (b <= CH_LOWER_Z));
  endfunction

endpackage
`default_nettype wire

[design/wlr_ifs.sv]
`timescale 1ns / 1ps
`default_nettype none
interface wlr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink   (input valid, input byte_in, output ready);
endinterface

interface wlr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_out;
  logic       run_last;
  logic       overflow;

  modport source (output valid, output byte_out, output run_last, output overflow,
                  input ready);
  modport sink   (input valid, input byte_out, input run_last, input overflow,
                  output ready);
endinterface
`default_nettype wire

[design/word_letter_reverser.sv]
// A separator reaching an empty stack goes from the queue through BK_SEP to the output register;
//   held letters are each read in BK_POP and loaded in BK_EMIT, then the separator follows.
// A letter is pushed in BK_IDLE; a separator or a split (letter on a full stack) first pops every
//   held letter, and the split letter then opens the next segment.
// A 2-entry queue lets the front take requests while the back drains the stack.
// Reset: rst_n synchronous, active low; clears stack count, queue and output valid.
`timescale 1ns / 1ps
`default_nettype none
module word_letter_reverser #(
  parameter int unsigned WORD_DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  wlr_in_if.sink     in_ch,
  wlr_out_if.source  out_ch
);
  import wlr_pkg::*;

  // stack count must hold WORD_DEPTH itself
  localparam int unsigned CW = $clog2(WORD_DEPTH + 1);

  // front -> queue
  logic          push_valid;
  wlr_item_t     push_item;
  logic          push_ready;

  // queue -> back
  logic          q_valid;
  wlr_item_t     q_item;
  logic          q_pop;

  logic [CW-1:0] stack_level;

  // Front: classifies each byte as letter or separator.
  wlr_front u_front (
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready)
  );

  // Queue: decouples the front from the back's pop sequences.
  wlr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready),
    .pop_valid  (q_valid),
    .pop_item   (q_item),
    .pop        (q_pop)
  );

  // Back: word stack, pop sequencer and output register.
  wlr_back #(
    .WORD_DEPTH (WORD_DEPTH),
    .CW         (CW)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .stack_level (stack_level),
    .out_ch      (out_ch)
  );

`ifndef SYNTHESIS
  // stack never holds more than its depth
  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stack_level <= CW'(WORD_DEPTH))
    else $error("stack level above depth");

  // a letter popped by a separator is never the last of its run
  a_pop_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && is_letter(out_ch.byte_out) && !out_ch.overflow) |-> !out_ch.run_last)
    else $error("separator pop marked last");

  // overflow results are only letters
  a_ovf_letter: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.overflow) |-> is_letter(out_ch.byte_out))
    else $error("overflow on non-letter");

  // stack grows by at most one per cycle
  a_level_step: assert property (@(posedge clk) disable iff (!rst_n)
    (stack_level > $past(stack_level)) |-> (stack_level == $past(stack_level) + CW'(1)))
    else $error("stack level jumped");
`endif

endmodule
`default_nettype wire

[design/wlr_front.sv]
`timescale 1ns / 1ps
`default_nettype none
module wlr_front (
  wlr_in_if.sink             in_ch,
  output logic               push_valid,
  output wlr_pkg::wlr_item_t push_item,
  input  logic               push_ready
);
  import wlr_pkg::*;

  // classify and hand over; stalls only when the queue is full
  assign in_ch.ready          = push_ready;
  assign push_valid           = in_ch.valid;
  assign push_item.byte_val   = in_ch.byte_in;
  assign push_item.is_letter  = is_letter(in_ch.byte_in);

endmodule
`default_nettype wire

[design/wlr_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
module wlr_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  input  wlr_pkg::wlr_item_t push_item,
  output logic               push_ready,
  output logic               pop_valid,
  output wlr_pkg::wlr_item_t pop_item,
  input  logic               pop
);
  import wlr_pkg::*;

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  wlr_item_t      slot_r [QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  fill_r, fill_nxt;
  logic           do_push, do_pop;

  assign push_ready = (fill_r != CW'(QUEUE_DEPTH));
  assign pop_valid  = (fill_r != '0);
  assign pop_item   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   fill_nxt = fill_r + CW'(1);
      2'b01:   fill_nxt = fill_r - CW'(1);
      default: fill_nxt = fill_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

[design/wlr_back.sv]
`timescale 1ns / 1ps
`default_nettype none
module wlr_back #(
  parameter int unsigned WORD_DEPTH = 32,
  parameter int unsigned CW         = 6
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  wlr_pkg::wlr_item_t q_item,
  output logic               q_pop,
  output logic [CW-1:0]      stack_level,
  wlr_out_if.source          out_ch
);
  import wlr_pkg::*;

  localparam int unsigned AW = (WORD_DEPTH > 1) ? $clog2(WORD_DEPTH) : 1;

  logic [7:0]    stack_mem [WORD_DEPTH];
  logic [7:0]    rd_data_r;

  back_state_t   state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  wlr_item_t     cur_r, cur_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    out_byte_r, out_byte_nxt;
  logic          out_last_r, out_last_nxt;
  logic          out_ovf_r, out_ovf_nxt;

  logic          mem_we;
  logic [7:0]    mem_wdata;
  logic          rd_en;
  logic [CW-1:0] count_dec;
  logic          load_ok;

  assign count_dec   = count_r - CW'(1);
  assign load_ok     = !out_valid_r || out_ch.ready;
  assign stack_level = count_r;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    cur_nxt       = cur_r;
    q_pop         = 1'b0;
    mem_we        = 1'b0;
    mem_wdata     = cur_r.byte_val;
    rd_en         = 1'b0;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;
    case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          q_pop   = 1'b1;
          cur_nxt = q_item;
          if (q_item.is_letter && (count_r < CW'(WORD_DEPTH))) begin
            mem_we    = 1'b1;
            mem_wdata = q_item.byte_val;
            count_nxt = count_r + CW'(1);
          end else if (count_r != '0) begin
            state_nxt = BK_POP;
          end else begin
            state_nxt = BK_SEP;
          end
        end
      end
      BK_POP: begin
        rd_en     = 1'b1;
        count_nxt = count_dec;
        state_nxt = BK_EMIT;
      end
      BK_EMIT: begin
        if (load_ok) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = rd_data_r;
          out_ovf_nxt   = cur_r.is_letter;
          out_last_nxt  = cur_r.is_letter && (count_r == '0);
          if (count_r != '0) begin
            state_nxt = BK_POP;
          end else if (cur_r.is_letter) begin
            // split word: the new letter opens the next segment
            mem_we    = 1'b1;
            count_nxt = CW'(1);
            state_nxt = BK_IDLE;
          end else begin
            state_nxt = BK_SEP;
          end
        end
      end
      BK_SEP: begin
        if (load_ok) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = cur_r.byte_val;
          out_last_nxt  = 1'b1;
          out_ovf_nxt   = 1'b0;
          state_nxt     = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  // word stack: write at count, registered read at count - 1
  always_ff @(posedge clk) begin
    if (mem_we) begin
      stack_mem[count_r[AW-1:0]] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data_r <= stack_mem[count_dec[AW-1:0]];
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.byte_out = out_byte_r;
  assign out_ch.run_last = out_last_r;
  assign out_ch.overflow = out_ovf_r;

endmodule
`default_nettype wire
